>>> rtl/mexp_pkg.sv
// ---------------------------------------------------------------------------
// mexp_pkg: shared types and constants for the modular exponentiation block
// Controller states, datapath operation codes, command and status words
// and configuration register indexes.
// ---------------------------------------------------------------------------
package mexp_pkg;

	// port width of every operand field
	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHKMOD,
		ST_CHECK,
		ST_MULT,
		ST_REDUCE,
		ST_WRITE,
		ST_FINISH
	} state_t;

	// which modular product the datapath forms
	typedef enum logic [1:0] {
		OP_BASE,   // base mod m
		OP_ACC,    // acc * base mod m
		OP_SQR     // base * base mod m
	} op_t;

	typedef struct packed {
		logic load;
		logic shift_e;
		logic mult;
		logic step;
		logic write;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic m_zero;
		logic e_zero;
		logic e_lsb;
		logic e_rest_zero;
		logic red_last;
	} status_t;

endpackage

>>> rtl/modular_exponentiation_top.sv
// ---------------------------------------------------------------------------
// modular_exponentiation_top: base ** exponent mod modulus
// Right-to-left square-and-multiply over a shared serial modular multiplier.
//
//  channel  | signals                              | handshake
//  ---------+--------------------------------------+-------------------------
//  config   | cfg_valid cfg_ready cfg_index cfg_data | valid & ready
//  input    | start busy exponent                   | start & !busy
//  result   | done power_result modulus_error       | done, one cycle
//
// Each modular multiply loads the product register, runs it through the
// two-bit-per-cycle reduction loop and writes the remainder back. A word
// takes one reduction of the base, then a multiply for each set exponent bit
// and a square for each bit below the top set one, at most 2*W multiplies.
// A new word is accepted only once the last one has finished. A zero modulus
// goes from the modulus check straight to the result strobe, modulus_error set.
// Reset clears the controller and sets base 0, modulus 1. The receiver
// cannot stall; busy stays high through the result strobe.
// ---------------------------------------------------------------------------
module modular_exponentiation_top #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mexp_pkg::DATA_W-1:0]    cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  logic [mexp_pkg::DATA_W-1:0]    exponent,
	output logic                           done,
	output logic [mexp_pkg::DATA_W-1:0]    power_result,
	output logic                           modulus_error
);
	import mexp_pkg::*;

	logic [DATA_W-1:0] base_q, modulus_q;
	cmd_t              cmd;
	status_t           status;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			modulus_q <= DATA_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BASE:    base_q <= cfg_data;
				CFG_MODULUS: modulus_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mexp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mexp_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.base_value    (base_q),
		.modulus_value (modulus_q),
		.exponent      (exponent),
		.status        (status),
		.power_result  (power_result),
		.modulus_error (modulus_error)
	);

endmodule

>>> rtl/mexp_ctrl.sv
// ---------------------------------------------------------------------------
// mexp_ctrl: square-and-multiply sequencer
// Walks the exponent bits, issuing one modular multiply per operation and
// waiting on the datapath reduction counter.
// ---------------------------------------------------------------------------
module mexp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mexp_pkg::status_t status,
	output mexp_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done
);
	import mexp_pkg::*;

	state_t state_q, state_d;
	op_t    op_q;
	logic   mul_done_q;   // multiply for the current exponent bit already done
	logic   want_mul;

	assign want_mul = status.e_lsb && !mul_done_q;

	// state register and operation tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_BASE;
			mul_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CHKMOD: begin
					op_q       <= OP_BASE;
					mul_done_q <= 1'b0;
				end
				ST_CHECK: begin
					if (want_mul) op_q <= OP_ACC;
					else op_q <= OP_SQR;
				end
				ST_WRITE: begin
					mul_done_q <= (op_q == OP_ACC);
				end
				default: begin
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_CHKMOD;
			ST_CHKMOD: state_d = status.m_zero ? ST_FINISH : ST_MULT;
			ST_CHECK: begin
				if (status.e_zero) state_d = ST_FINISH;
				else if (want_mul) state_d = ST_MULT;
				else if (status.e_rest_zero) state_d = ST_FINISH;
				else state_d = ST_MULT;
			end
			ST_MULT:   state_d = ST_REDUCE;
			ST_REDUCE: if (status.red_last) state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_CHECK;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.shift_e = (state_q == ST_CHECK) && !status.e_zero && !want_mul;
		cmd.mult    = (state_q == ST_MULT);
		cmd.step    = (state_q == ST_REDUCE);
		cmd.write   = (state_q == ST_WRITE);
		cmd.op      = op_q;
		busy        = (state_q != ST_IDLE);
		done        = (state_q == ST_FINISH);
	end

endmodule

>>> rtl/mexp_dp.sv
// ---------------------------------------------------------------------------
// mexp_dp: modular multiply datapath
// One multiplier feeding a product register, reduced by a restoring
// shift-subtract divider that retires two product bits a cycle.
// ---------------------------------------------------------------------------
module mexp_dp #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mexp_pkg::cmd_t              cmd,
	input  logic [mexp_pkg::DATA_W-1:0] base_value,
	input  logic [mexp_pkg::DATA_W-1:0] modulus_value,
	input  logic [mexp_pkg::DATA_W-1:0] exponent,
	output mexp_pkg::status_t           status,
	output logic [mexp_pkg::DATA_W-1:0] power_result,
	output logic                        modulus_error
);
	import mexp_pkg::*;

	localparam int W     = OPERAND_WIDTH;
	localparam int CNT_W = $clog2(W);

	logic [W-1:0]     b_q, acc_q, e_q, m_q, rem_q;
	logic [2*W-1:0]   prod_q, prod_d;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     op_a, op_b;
	logic [W:0]       m_ext, r1_raw, r1, r2_raw, r2;

	// multiplier operand select
	always_comb begin
		op_a   = (cmd.op == OP_ACC) ? acc_q : b_q;
		op_b   = (cmd.op == OP_BASE) ? W'(1) : b_q;
		prod_d = {{W{1'b0}}, op_a} * {{W{1'b0}}, op_b};
	end

	// two restoring division steps
	always_comb begin
		m_ext  = {1'b0, m_q};
		r1_raw = {rem_q, prod_q[2*W-1]};
		r1     = (r1_raw >= m_ext) ? (r1_raw - m_ext) : r1_raw;
		r2_raw = {r1[W-1:0], prod_q[2*W-2]};
		r2     = (r2_raw >= m_ext) ? (r2_raw - m_ext) : r2_raw;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mult) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// operand, product and remainder registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			b_q   <= base_value[W-1:0];
			m_q   <= modulus_value[W-1:0];
			e_q   <= exponent[W-1:0];
			acc_q <= W'(1);
		end
		if (cmd.shift_e) e_q <= {1'b0, e_q[W-1:1]};
		if (cmd.mult) begin
			prod_q <= prod_d;
			rem_q  <= '0;
		end else if (cmd.step) begin
			prod_q <= {prod_q[2*W-3:0], 2'b00};
			rem_q  <= r2[W-1:0];
		end
		if (cmd.write) begin
			if (cmd.op == OP_ACC) acc_q <= rem_q;
			else b_q <= rem_q;
		end
	end

	// status and result
	always_comb begin
		status.m_zero      = (m_q == '0);
		status.e_zero      = (e_q == '0);
		status.e_lsb       = e_q[0];
		status.e_rest_zero = (e_q[W-1:1] == '0);
		status.red_last    = (cnt_q == CNT_W'(W - 1));
		modulus_error      = status.m_zero;
		power_result       = status.m_zero ? '0 : DATA_W'(acc_q);
	end

endmodule

>>> bench/modular_exponentiation_top_test.sv
// ---------------------------------------------------------------------------
// modular_exponentiation_top_test: self-checking bench for modular exponentiation
// A directed table covers the reset operands, zero modulus, modulus one and the
// 32-bit extremes. Random phases follow. Each phase loads base, modulus or both
// while the block is idle, then sends exponent words with random gaps. Every result
// word is checked against its table value or a square-and-multiply predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module modular_exponentiation_top_test;
	import mexp_pkg::*;

	localparam int OPERAND_WIDTH = 32;
	localparam int RANDOM_WORDS  = 248;
	localparam int SETTLE_CYCLES = 50;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              err;
	} power_word_t;

	typedef struct packed {
		logic              load;
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] modulus;
		logic [DATA_W-1:0] exponent;
		logic              fixed;
		power_word_t       want;
	} stim_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
	logic [DATA_W-1:0]    cfg_data  = '0;
	logic                 start     = 1'b0;
	logic                 busy;
	logic [DATA_W-1:0]    exponent  = '0;
	logic                 done;
	logic [DATA_W-1:0]    power_result;
	logic                 modulus_error;

	// operand registers as the block should hold them
	logic [DATA_W-1:0] cur_base    = '0;
	logic [DATA_W-1:0] cur_modulus = 'd1;

	power_word_t expected_q[$];
	stim_row_t   directed_q[$];
	int          errors = 0;

	modular_exponentiation_top #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.exponent     (exponent),
		.done         (done),
		.power_result (power_result),
		.modulus_error(modulus_error)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// right-to-left square-and-multiply; acc starts at 1 and is reduced only on multiply
	function automatic power_word_t predict_power(input logic [DATA_W-1:0] b_in,
			input logic [DATA_W-1:0] m_in, input logic [DATA_W-1:0] e_in);
		logic [63:0] mask;
		logic [63:0] m;
		logic [63:0] b;
		logic [63:0] e;
		logic [63:0] acc;
		power_word_t res;
		mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
		m    = {32'd0, m_in} & mask;
		b    = {32'd0, b_in} & mask;
		e    = {32'd0, e_in} & mask;
		acc  = 64'd1;
		if (m == 64'd0) begin
			res.value = '0;
			res.err   = 1'b1;
		end else begin
			b = b % m;
			for (int i = 0; i < OPERAND_WIDTH && e != 64'd0; i++) begin
				if (e[0])
					acc = (acc * b) % m;
				e = e >> 1;
				b = (b * b) % m;
			end
			acc       = acc & mask;
			res.value = acc[DATA_W-1:0];
			res.err   = 1'b0;
		end
		return res;
	endfunction

	// exponent mix: mostly full range, plus short, one-hot and dense words
	function automatic logic [DATA_W-1:0] draw_exponent();
		logic [DATA_W-1:0] e;
		case ($urandom_range(0, 9))
			6: e = $urandom_range(0, 16);
			7: e = 32'd1 << $urandom_range(0, 31);
			8: e = ~(32'd1 << $urandom_range(0, 31));
			9: e = 32'hFFFF_FFFF;
			default: e = $urandom;
		endcase
		return e;
	endfunction

	task automatic add_row(input logic load, input logic [DATA_W-1:0] b,
			input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] e,
			input logic fixed, input logic [DATA_W-1:0] want_value, input logic want_err);
		stim_row_t r;
		r.load       = load;
		r.base       = b;
		r.modulus    = m;
		r.exponent   = e;
		r.fixed      = fixed;
		r.want.value = want_value;
		r.want.err   = want_err;
		directed_q.push_back(r);
	endtask

	// hold off the sender until every outstanding result word is back
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (expected_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// one config word; valid stays high so back-to-back writes need one assignment per step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_BASE)
			cur_base = val;
		else
			cur_modulus = val;
	endtask

	task automatic load_operands(input logic wr_base, input logic wr_mod,
			input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] m);
		if (wr_base)
			write_reg(CFG_BASE, b);
		if (wr_mod)
			write_reg(CFG_MODULUS, m);
		cfg_valid <= 1'b0;
	endtask

	// start stays high across back-to-back words; lowered only by pause or drain
	task automatic send_exponent(input logic [DATA_W-1:0] e, input logic fixed,
			input power_word_t want);
		start    <= 1'b1;
		exponent <= e;
		do
			@(posedge clk);
		while (busy);
		expected_q.push_back(fixed ? want : predict_power(cur_base, cur_modulus, e));
	endtask

	// result checker: one word per done strobe
	always @(posedge clk) begin : result_check
		power_word_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, power_result %h modulus_error %b",
					$time, power_result, modulus_error);
			end else begin
				want = expected_q.pop_front();
				if (power_result !== want.value) begin
					errors++;
					$display("%0t: power_result expected %h, got %h",
						$time, want.value, power_result);
				end
				if (modulus_error !== want.err) begin
					errors++;
					$display("%0t: modulus_error expected %b, got %b",
						$time, want.err, modulus_error);
				end
			end
		end
	end

	initial begin : stimulus
		stim_row_t         r;
		int                words_sent;
		int                phase_len;
		int                gap_max;
		int                wr_sel;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] m;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset operands: base 0, modulus 1
		add_row(1'b0, 32'd0, 32'd1, 32'd0,         1'b1, 32'd1, 1'b0);
		add_row(1'b0, 32'd0, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0);
		// zero modulus flags an error
		add_row(1'b1, 32'd2, 32'd0, 32'd5,         1'b1, 32'd0, 1'b1);
		add_row(1'b0, 32'd2, 32'd0, 32'd0,         1'b1, 32'd0, 1'b1);
		add_row(1'b0, 32'd2, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1);
		// modulus one: exponent zero still gives 1
		add_row(1'b1, 32'd7, 32'd1, 32'd0,         1'b1, 32'd1, 1'b0);
		add_row(1'b0, 32'd7, 32'd1, 32'd3,         1'b1, 32'd0, 1'b0);
		// zero base
		add_row(1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd1, 1'b0);
		add_row(1'b0, 32'd0, 32'hFFFF_FFFF, 32'd9, 1'b1, 32'd0, 1'b0);
		// base equal to modulus reduces to zero
		add_row(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0);
		// base = -1 mod m
		add_row(1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'hFFFF_FFFE, 1'b0);
		add_row(1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd2, 1'b1, 32'd1, 1'b0);
		add_row(1'b0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0);
		add_row(1'b1, 32'd2, 32'd1000, 32'd10,     1'b1, 32'd24, 1'b0);
		// base above modulus
		add_row(1'b1, 32'd1000, 32'd7, 32'd1,      1'b1, 32'd6, 1'b0);
		add_row(1'b1, 32'd3, 32'hFFFF_FFFB, 32'hFFFF_FFFA, 1'b0, 32'd0, 1'b0);
		add_row(1'b0, 32'd3, 32'hFFFF_FFFB, 32'h8000_0000, 1'b0, 32'd0, 1'b0);
		add_row(1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'd0, 1'b0);
		add_row(1'b1, 32'd12345, 32'd2, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0);
		add_row(1'b1, 32'hDEAD_BEEF, 32'h8000_0001, 32'hAAAA_AAAA, 1'b0, 32'd0, 1'b0);
		add_row(1'b0, 32'hDEAD_BEEF, 32'h8000_0001, 32'h5555_5555, 1'b0, 32'd0, 1'b0);
		add_row(1'b1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0);

		// directed table
		foreach (directed_q[i]) begin
			r = directed_q[i];
			if (r.load) begin
				drain();
				load_operands(1'b1, 1'b1, r.base, r.modulus);
			end
			pause($urandom_range(0, 10));
			send_exponent(r.exponent, r.fixed, r.want);
		end

		// random phases, new operands for each while idle
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			drain();
			b = $urandom;
			m = $urandom;
			case ($urandom_range(0, 7))
				1: m = '0;
				2: m = 32'd1;
				3: begin
					m = 32'hFFFF_FFFF;
					if ($urandom_range(0, 1))
						b = 32'hFFFF_FFFF;
				end
				4: m = $urandom_range(2, 1000);
				5: b = $urandom_range(0, 1);
				6: begin
					m = m | 32'h8000_0000;
					b = m - 32'd1;
				end
				default: ;
			endcase
			wr_sel = $urandom_range(0, 2);
			load_operands(wr_sel != 2, wr_sel != 1, b, m);
			phase_len = $urandom_range(10, 40);
			// last phase stops at the word budget
			if (phase_len > RANDOM_WORDS - words_sent)
				phase_len = RANDOM_WORDS - words_sent;
			gap_max   = $urandom_range(0, 1) ? 10 : 0;
			repeat (phase_len) begin
				if ($urandom_range(0, 19) == 0)
					drain();
				pause($urandom_range(0, gap_max));
				send_exponent(draw_exponent(), 1'b0, '0);
				words_sent++;
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("modular_exponentiation_top: match");
		else
			$display("modular_exponentiation_top: mismatch");
		$finish;
	end

	// watchdog: several times the slowest legal run of all 270 words
	initial begin : watchdog
		#12_000_000;
		$display("modular_exponentiation_top: mismatch");
		$finish;
	end

endmodule
